@@ design/rsn_pkg.sv @@
// Package with shared types and constants of the radar sample normalizer.
`timescale 1ns / 1ps

package rsn_pkg;

    localparam int SMP_W      = 48;
    localparam int PROD_W     = 24;
    localparam int DEN_W      = 33;
    localparam int MULT_W     = 9;
    localparam int DIVIDEND_W = 52;
    localparam int DIVISOR_W  = 44;
    localparam int QUOT_W     = 41;
    localparam int RES_W      = 50;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [2:0]        REGION_LOW  = 3'd3;
    localparam logic [MULT_W-1:0] DIV_LOW     = 9'd306;
    localparam logic [MULT_W-1:0] DIV_HIGH    = 9'd316;
    localparam logic [MULT_W-1:0] DIV_RF      = 9'd1;
    localparam logic [11:0]       DAC_SPAN    = 12'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DDC_ENABLE  = 3'd0,
        CFG_REGION      = 3'd1,
        CFG_DAC_STEP    = 3'd2,
        CFG_PULSES      = 3'd3,
        CFG_ITERATIONS  = 3'd4,
        CFG_DAC_MIN     = 3'd5,
        CFG_DAC_MAX     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic        ddc_enable;
        logic [2:0]  region_code;
        logic [1:0]  dac_step_log2;
        logic [15:0] pulses_per_step;
        logic [7:0]  sweep_iterations;
        logic [10:0] dac_min;
        logic [10:0] dac_max;
    } cfg_t;

endpackage

@@ design/radar_sample_normalizer.sv @@
// Top level of the radar sample normalizer: sequencer, operand setup and result stage.
`timescale 1ns / 1ps

// Each sample beat goes from acceptance to the result register through the
// two multiplies that build the divisor, the start of the divider, the
// bit-serial divider that is shared by every sample, the step in which the
// divider reports completion, and the load of the result. The input is not
// ready again until the result is loaded, so a new sample is accepted only
// after the previous result has been loaded. A sample with a zero iteration
// or pulse count skips the arithmetic and goes straight to the final state,
// where it is loaded into the result register. The output register lets a
// finished result wait for the consumer while the next sample is accepted;
// a second result waits in its final state until the first one is taken.

module radar_sample_normalizer
    import rsn_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // [47:0] sample
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [47:0] normalized
    output logic [1:0]            m_tuser,   // [0] saturated, [1] config_error
    output logic                  m_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL1 = 6'b000010,
        ST_MUL2 = 6'b000100,
        ST_DIVS = 6'b001000,
        ST_DIVW = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    cfg_t cfg;

    state_t            state_reg;
    state_t            state_next;
    logic [SMP_W-1:0]  mag_reg;
    logic              neg_reg;
    logic              last_reg;
    logic              odd_item_reg;
    logic              err_reg;
    logic              odd_reg;
    logic              odd_next;
    logic [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [47:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic              m_tlast_reg;

    logic                  in_beat;
    logic                  out_load;
    logic                  cfg_zero;
    logic [SMP_W-1:0]      x_mag;
    logic [MULT_W-1:0]     mult;
    logic [50:0]           num;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic                  div_start;
    logic                  div_done;
    logic [QUOT_W-1:0]     quo;
    logic [RES_W-1:0]      q_ext;
    logic [RES_W-1:0]      sq;
    logic [11:0]           dac_diff;
    logic [RES_W-1:0]      offset;
    logic [RES_W-1:0]      res;
    logic                  res_sat;
    logic [47:0]           res_clamped;

    rsn_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsn_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign cfg_zero = (cfg.sweep_iterations == 8'd0) || (cfg.pulses_per_step == 16'd0);
    assign x_mag    = s_tdata[47] ? (~s_tdata + 1'b1) : s_tdata;

    always_comb begin
        if (cfg.ddc_enable) begin
            mult = (cfg.region_code == REGION_LOW) ? DIV_LOW : DIV_HIGH;
        end else begin
            mult = DIV_RF;
        end
    end

    assign num       = 51'(mag_reg) << cfg.dac_step_log2;
    assign dividend  = {num, 1'b0} + DIVIDEND_W'({den_reg, 10'b0});
    assign divisor   = {den_reg, 11'b0};
    assign div_start = (state_reg == ST_DIVS);

    assign q_ext    = RES_W'(quo);
    assign sq       = neg_reg ? (~q_ext + 1'b1) : q_ext;
    assign dac_diff = DAC_SPAN + 12'(cfg.dac_min) - 12'(cfg.dac_max);
    assign offset   = RES_W'(dac_diff) << (FRAC_BITS - 1);

    always_comb begin
        if (cfg.ddc_enable) begin
            res = odd_item_reg ? (~sq + 1'b1) : sq;
        end else begin
            res = sq + offset;
        end
        res_sat     = !((res[RES_W-1:47] == 3'b000) || (res[RES_W-1:47] == 3'b111));
        res_clamped = res[47:0];
        if (res_sat) begin
            res_clamped = res[RES_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    state_next = cfg_zero ? ST_FIN : ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIVS;
            ST_DIVS: state_next = ST_DIVW;
            ST_DIVW: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        odd_next = odd_reg;
        if (in_beat) begin
            odd_next = s_tlast ? 1'b0 : !odd_reg;
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            odd_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            odd_reg      <= odd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            mag_reg      <= x_mag;
            neg_reg      <= s_tdata[47];
            last_reg     <= s_tlast;
            odd_item_reg <= odd_reg;
            err_reg      <= cfg_zero;
        end
        if (state_reg == ST_MUL1) begin
            prod_reg <= PROD_W'(cfg.sweep_iterations) * PROD_W'(cfg.pulses_per_step);
        end
        if (state_reg == ST_MUL2) begin
            den_reg <= DEN_W'(prod_reg) * DEN_W'(mult);
        end
        if (out_load) begin
            m_tdata_reg <= err_reg ? 48'd0 : res_clamped;
            m_tuser_reg <= {err_reg, err_reg ? 1'b0 : res_sat};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ design/rsn_cfg_regs.sv @@
// Configuration register file of the radar sample normalizer.
`timescale 1ns / 1ps

module rsn_cfg_regs
    import rsn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DDC_ENABLE: cfg_next.ddc_enable       = cfg_data[0];
                CFG_REGION:     cfg_next.region_code      = cfg_data[2:0];
                CFG_DAC_STEP:   cfg_next.dac_step_log2    = cfg_data[1:0];
                CFG_PULSES:     cfg_next.pulses_per_step  = cfg_data[15:0];
                CFG_ITERATIONS: cfg_next.sweep_iterations = cfg_data[7:0];
                CFG_DAC_MIN:    cfg_next.dac_min          = cfg_data[10:0];
                CFG_DAC_MAX:    cfg_next.dac_max          = cfg_data[10:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ddc_enable       <= 1'b0;
            cfg_reg.region_code      <= 3'd3;
            cfg_reg.dac_step_log2    <= 2'd0;
            cfg_reg.pulses_per_step  <= 16'd1;
            cfg_reg.sweep_iterations <= 8'd1;
            cfg_reg.dac_min          <= 11'd0;
            cfg_reg.dac_max          <= 11'd2047;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/rsn_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module rsn_divider
    import rsn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [QUOT_W-1:0]    quo_reg;
    logic [QUOT_W-1:0]    quo_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 qbit;

    assign trial    = {rem_reg, quo_reg[QUOT_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign qbit     = (trial >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    // The top bits of the dividend start as the remainder; they are known
    // to be below the divisor, so only the low bits produce quotient bits.
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
            quo_next  = dividend[QUOT_W-1:0];
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[QUOT_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

endmodule

@@ design/rsn_checker.sv @@
// Port-level checker of the radar sample normalizer and its bind statement.
`timescale 1ns / 1ps

module rsn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) begin
            pend_next = pend_reg + 1'b1;
        end else if (!in_beat && out_beat) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A result beat must belong to a sample that was accepted earlier.
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != 2'd0))
        else $error("result beat without a pending sample");

    // At most one sample in work and one result held.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == 2'd2) |-> !s_tready)
        else $error("sample accepted while two are pending");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> ((m_tdata == 48'd0) && !m_tuser[0]))
        else $error("configuration error result is not zero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat dropped or changed while stalled");

endmodule

bind radar_sample_normalizer rsn_checker u_rsn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
